@@ rtl/height_table_drag_force_defines.svh @@
// ----------------------------------------------------------------------------
// height table drag force assertion macros
// concurrent checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TABLE_DRAG_FORCE_DEFINES_SVH
`define HEIGHT_TABLE_DRAG_FORCE_DEFINES_SVH
`ifndef SYNTH
`define HTDF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("htdf assertion failed");
`define HTDF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("htdf assertion failed");
`else
`define HTDF_ASSERT(label, clk, rst, prop)
`define HTDF_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ rtl/htdf_pkg.sv @@
// ----------------------------------------------------------------------------
// htdf_pkg
// types, constants and fixed-point helpers of the height table drag force block
// ----------------------------------------------------------------------------
package htdf_pkg;

   localparam int DATA_W       = 32;
   localparam int FRAC_BITS    = 16;
   localparam int TABLE_POINTS = 16;
   localparam int IDX_W        = 4;
   localparam int CNT_W        = 5;
   localparam int DIV_STEPS    = DATA_W;
   localparam int ROOT_STEPS   = DATA_W;
   localparam int WIDE_W       = 2 * DATA_W;

   localparam logic [CNT_W-1:0]         MIN_POINTS   = CNT_W'(2);
   localparam logic [CNT_W-1:0]         MAX_POINTS   = CNT_W'(TABLE_POINTS);
   localparam logic [CNT_W-1:0]         POINTS_RESET = CNT_W'(2);
   localparam logic signed [DATA_W-1:0] GAIN_RESET   = DATA_W'(1 << FRAC_BITS);

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_COMPUTE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_GAIN_X        = 2'd0,
      CSR_GAIN_Y        = 2'd1,
      CSR_GAIN_Z        = 2'd2,
      CSR_POINTS_IN_USE = 2'd3
   } csr_idx_type;

   typedef struct packed {
      cmd_type                  command;
      logic [IDX_W-1:0]         point_index;
      logic signed [DATA_W-1:0] height;
      logic signed [DATA_W-1:0] coefficient;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
      logic signed [DATA_W-1:0] interp_coeff;
      logic                     above_table;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } gain_set_type;

   typedef struct packed {
      logic                     hit;
      logic                     first;
      logic signed [DATA_W-1:0] yl;
      logic signed [DATA_W-1:0] yu;
      logic signed [DATA_W-1:0] cl;
      logic signed [DATA_W-1:0] cu;
   } look_type;

   typedef struct packed {
      logic                     hit;
      logic                     first;
      logic                     dc_neg;
      logic signed [DATA_W-1:0] cl;
      logic signed [DATA_W-1:0] cu;
      logic [2:0][DATA_W-1:0]   vel;
   } band_type;

   typedef struct packed {
      logic                   hit;
      logic [DATA_W-1:0]      coeff;
      logic [DATA_W-1:0]      speed;
      logic [2:0][DATA_W-1:0] vel;
   } coef_type;

   typedef struct packed {
      logic              sat;
      logic [DATA_W-1:0] value;
   } mulq_type;

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
      return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
   endfunction

   // operands carry their sign in the top bit
   function automatic mulq_type mulq(input logic [DATA_W:0] a, input logic [DATA_W:0] b,
                                     input logic negate);
      logic [DATA_W:0]             ma;
      logic [DATA_W:0]             mb;
      logic [2*DATA_W+1:0]         prod;
      logic [2*DATA_W+1-FRAC_BITS:0] p;
      logic                        neg;
      mulq_type                    r;
      ma   = a[DATA_W] ? (~a + (DATA_W+1)'(1)) : a;
      mb   = b[DATA_W] ? (~b + (DATA_W+1)'(1)) : b;
      prod = (2*DATA_W+2)'(ma) * (2*DATA_W+2)'(mb);
      p    = prod[2*DATA_W+1:FRAC_BITS];
      neg  = (a[DATA_W] ^ b[DATA_W]) ^ negate;
      r.sat = 1'b0;
      if (neg) begin
         if ((|p[2*DATA_W+1-FRAC_BITS:DATA_W]) || (p[DATA_W-1] && (|p[DATA_W-2:0]))) begin
            r.sat   = 1'b1;
            r.value = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            r.value = ~p[DATA_W-1:0] + DATA_W'(1);
         end
      end else begin
         if (|p[2*DATA_W+1-FRAC_BITS:DATA_W-1]) begin
            r.sat   = 1'b1;
            r.value = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            r.value = p[DATA_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/htdf_lookup.sv @@
// ----------------------------------------------------------------------------
// htdf_lookup
// point table in flops, parallel first-hit search and bracketing pair select
// ----------------------------------------------------------------------------
module htdf_lookup (
   input  logic                             clock,
   input  logic                             en,
   input  logic                             wr,
   input  logic [htdf_pkg::IDX_W-1:0]       wr_index,
   input  logic [htdf_pkg::DATA_W-1:0]      wr_height,
   input  logic [htdf_pkg::DATA_W-1:0]      wr_coeff,
   input  logic [htdf_pkg::CNT_W-1:0]       points_in_use,
   input  logic [htdf_pkg::DATA_W-1:0]      height,
   output htdf_pkg::look_type               look
);
   import htdf_pkg::*;

   logic signed [DATA_W-1:0] ht_ff [TABLE_POINTS];
   logic signed [DATA_W-1:0] cf_ff [TABLE_POINTS];
   logic [CNT_W-1:0]         n_in;
   logic [TABLE_POINTS-1:0]  hitv;
   logic [TABLE_POINTS-1:0]  fh;
   look_type                 look_in;
   look_type                 look_ff;

   always_ff @(posedge clock) begin
      if (wr) begin
         ht_ff[wr_index] <= wr_height;
         cf_ff[wr_index] <= wr_coeff;
      end
   end

   always_comb begin
      n_in = points_in_use;
      if (points_in_use < MIN_POINTS) begin
         n_in = MIN_POINTS;
      end else if (points_in_use > MAX_POINTS) begin
         n_in = MAX_POINTS;
      end
      for (int j = 0; j < TABLE_POINTS; j++) begin
         hitv[j] = (CNT_W'(j) < n_in) && (ht_ff[j] >= $signed(height));
      end
      // lowest set bit
      fh = hitv & (~hitv + TABLE_POINTS'(1));
      look_in       = '0;
      look_in.hit   = |hitv;
      look_in.first = fh[0];
      for (int j = 0; j < TABLE_POINTS; j++) begin
         look_in.yu = look_in.yu | (ht_ff[j] & {DATA_W{fh[j]}});
         look_in.cu = look_in.cu | (cf_ff[j] & {DATA_W{fh[j]}});
      end
      for (int j = 1; j < TABLE_POINTS; j++) begin
         look_in.yl = look_in.yl | (ht_ff[j-1] & {DATA_W{fh[j]}});
         look_in.cl = look_in.cl | (cf_ff[j-1] & {DATA_W{fh[j]}});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         look_ff <= look_in;
      end
   end

   assign look = look_ff;

endmodule

@@ rtl/htdf_div.sv @@
// ----------------------------------------------------------------------------
// htdf_div
// pipelined restoring divider, one quotient bit per stage, carries the beat
// ----------------------------------------------------------------------------
module htdf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [htdf_pkg::WIDE_W-1:0]   in_num,
   input  logic [htdf_pkg::DATA_W-1:0]   in_den,
   input  htdf_pkg::band_type            in_band,
   output logic                          out_valid,
   output logic [htdf_pkg::DATA_W-1:0]   out_q,
   output htdf_pkg::band_type            out_band
);
   import htdf_pkg::*;

   logic [DATA_W-1:0] rem_ff  [DIV_STEPS];
   logic [DATA_W-1:0] lo_ff   [DIV_STEPS];
   logic [DATA_W-1:0] q_ff    [DIV_STEPS];
   logic [DATA_W-1:0] den_ff  [DIV_STEPS];
   band_type          band_ff [DIV_STEPS];
   logic              vld_ff  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DATA_W-1:0] rem_prev;
      logic [DATA_W-1:0] lo_prev;
      logic [DATA_W-1:0] q_prev;
      logic [DATA_W-1:0] den_prev;
      band_type          band_prev;
      logic              vld_prev;
      logic [DATA_W:0]   trial;
      logic              ge;
      logic [DATA_W-1:0] rem_in;

      if (k == 0) begin : g_head
         assign rem_prev  = in_num[WIDE_W-1:DATA_W];
         assign lo_prev   = in_num[DATA_W-1:0];
         assign q_prev    = '0;
         assign den_prev  = in_den;
         assign band_prev = in_band;
         assign vld_prev  = in_valid;
      end else begin : g_body
         assign rem_prev  = rem_ff[k-1];
         assign lo_prev   = lo_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign band_prev = band_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign trial  = {rem_prev, lo_prev[DATA_W-1]};
      assign ge     = trial >= {1'b0, den_prev};
      assign rem_in = ge ? DATA_W'(trial - {1'b0, den_prev}) : trial[DATA_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            lo_ff[k]   <= {lo_prev[DATA_W-2:0], 1'b0};
            q_ff[k]    <= {q_prev[DATA_W-2:0], ge};
            den_ff[k]  <= den_prev;
            band_ff[k] <= band_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_q     = q_ff[DIV_STEPS-1];
   assign out_band  = band_ff[DIV_STEPS-1];

endmodule

@@ rtl/htdf_sqrt.sv @@
// ----------------------------------------------------------------------------
// htdf_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module htdf_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [htdf_pkg::WIDE_W-1:0]   in_val,
   output logic [htdf_pkg::DATA_W-1:0]   out_root
);
   import htdf_pkg::*;

   logic [WIDE_W-1:0] rem_ff [ROOT_STEPS];
   logic [WIDE_W-1:0] res_ff [ROOT_STEPS];

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam logic [WIDE_W-1:0] STEP_BIT = WIDE_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      logic [WIDE_W-1:0] rem_prev;
      logic [WIDE_W-1:0] res_prev;
      logic [WIDE_W-1:0] sum_t;
      logic              ge;
      logic [WIDE_W-1:0] rem_in;
      logic [WIDE_W-1:0] res_in;

      if (k == 0) begin : g_head
         assign rem_prev = in_val;
         assign res_prev = '0;
      end else begin : g_body
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      assign sum_t  = res_prev + STEP_BIT;
      assign ge     = rem_prev >= sum_t;
      assign rem_in = ge ? (rem_prev - sum_t) : rem_prev;
      assign res_in = ge ? ((res_prev >> 1) + STEP_BIT) : (res_prev >> 1);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign out_root = res_ff[ROOT_STEPS-1][DATA_W-1:0];

endmodule

@@ rtl/htdf_force.sv @@
// ----------------------------------------------------------------------------
// htdf_force
// three multiply stages: coefficient by speed, by axis gain, by velocity
// ----------------------------------------------------------------------------
module htdf_force (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  htdf_pkg::coef_type      in_coef,
   input  htdf_pkg::gain_set_type  gains,
   output logic                    out_valid,
   output htdf_pkg::rsp_type       out_rsp
);
   import htdf_pkg::*;

   logic [2:0][DATA_W-1:0] gain_vec;
   mulq_type               k_in;
   mulq_type               w_in [3];
   mulq_type               f_in [3];

   logic                   m1_valid_ff;
   logic                   m1_hit_ff;
   logic [DATA_W-1:0]      m1_k_ff;
   logic                   m1_sat_ff;
   logic [DATA_W-1:0]      m1_coeff_ff;
   logic [2:0][DATA_W-1:0] m1_vel_ff;

   logic                   m2_valid_ff;
   logic                   m2_hit_ff;
   logic [2:0][DATA_W-1:0] m2_w_ff;
   logic                   m2_sat_ff;
   logic [DATA_W-1:0]      m2_coeff_ff;
   logic [2:0][DATA_W-1:0] m2_vel_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_in;
   rsp_type                rsp_ff;

   assign gain_vec = {gains.z, gains.y, gains.x};

   always_comb begin
      k_in = mulq({in_coef.coeff[DATA_W-1], in_coef.coeff}, {1'b0, in_coef.speed}, 1'b0);
      for (int a = 0; a < 3; a++) begin
         w_in[a] = mulq({m1_k_ff[DATA_W-1], m1_k_ff},
                        {gain_vec[a][DATA_W-1], gain_vec[a]}, 1'b0);
         f_in[a] = mulq({m2_w_ff[a][DATA_W-1], m2_w_ff[a]},
                        {m2_vel_ff[a][DATA_W-1], m2_vel_ff[a]}, 1'b1);
      end
      rsp_in.force_x      = f_in[0].value;
      rsp_in.force_y      = f_in[1].value;
      rsp_in.force_z      = f_in[2].value;
      rsp_in.interp_coeff = m2_coeff_ff;
      rsp_in.above_table  = !m2_hit_ff;
      rsp_in.saturated    = m2_sat_ff | f_in[0].sat | f_in[1].sat | f_in[2].sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_hit_ff   <= in_coef.hit;
         m1_k_ff     <= k_in.value;
         m1_sat_ff   <= k_in.sat;
         m1_coeff_ff <= in_coef.coeff;
         m1_vel_ff   <= in_coef.vel;
         m2_hit_ff   <= m1_hit_ff;
         m2_w_ff     <= {w_in[2].value, w_in[1].value, w_in[0].value};
         m2_sat_ff   <= m1_sat_ff | w_in[0].sat | w_in[1].sat | w_in[2].sat;
         m2_coeff_ff <= m1_coeff_ff;
         m2_vel_ff   <= m1_vel_ff;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff  <= in_valid;
         m2_valid_ff  <= m1_valid_ff;
         rsp_valid_ff <= m2_valid_ff;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

@@ rtl/height_table_drag_force.sv @@
// ----------------------------------------------------------------------------
// height_table_drag_force
// compute path: s0-s3 registers, divider, coefficient register, force stages
// one beat per cycle unless rsp stalls; divider and root are 32-stage pipes
// load beats write the table at acceptance and give no result
// back-pressure on rsp freezes the whole pipe; req_stall follows it
// reset (synchronous) clears valid bits and configuration registers, table is left as is
// ----------------------------------------------------------------------------
`include "height_table_drag_force_defines.svh"

module height_table_drag_force (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  htdf_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output htdf_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  htdf_pkg::csr_idx_type         csr_index,
   input  logic [htdf_pkg::DATA_W-1:0]   csr_data
);
   import htdf_pkg::*;

   logic                   en;
   logic                   accept;
   logic                   wr;
   gain_set_type           gains_ff;
   logic [CNT_W-1:0]       points_ff;

   logic                   s0_valid_ff;
   logic [DATA_W-1:0]      s0_h_ff;
   logic [2:0][DATA_W-1:0] s0_vel_ff;

   look_type               look;
   logic                   s1_valid_ff;
   logic [DATA_W-1:0]      s1_h_ff;
   logic [2:0][DATA_W-1:0] s1_vel_ff;
   logic [2:0][WIDE_W-1:0] sq_in;
   logic [2:0][WIDE_W-1:0] s1_sq_ff;

   logic [DATA_W:0]        dc_in;
   band_type               band_in;
   logic [DATA_W-1:0]      dc_mag_in;
   logic [DATA_W-1:0]      dh_in;
   logic [DATA_W-1:0]      den_in;
   logic [WIDE_W-1:0]      sumsq_in;
   logic                   s2_valid_ff;
   band_type               s2_band_ff;
   logic [DATA_W-1:0]      s2_dc_mag_ff;
   logic [DATA_W-1:0]      s2_dh_ff;
   logic [DATA_W-1:0]      s2_den_ff;
   logic [WIDE_W-1:0]      s2_sumsq_ff;

   logic                   s3_valid_ff;
   band_type               s3_band_ff;
   logic [WIDE_W-1:0]      s3_num_ff;
   logic [DATA_W-1:0]      s3_den_ff;
   logic [WIDE_W-1:0]      s3_sumsq_ff;

   logic                   dv_valid;
   logic [DATA_W-1:0]      dv_q;
   band_type               dv_band;
   logic [DATA_W-1:0]      root;

   logic [DATA_W:0]        interp_in;
   coef_type               coef_in;
   coef_type               coef_ff;
   logic                   coef_valid_ff;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;
   assign wr        = accept && (req_data.command == CMD_LOAD);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff  <= '{x: GAIN_RESET, y: GAIN_RESET, z: GAIN_RESET};
         points_ff <= POINTS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_X:        gains_ff.x <= csr_data;
            CSR_GAIN_Y:        gains_ff.y <= csr_data;
            CSR_GAIN_Z:        gains_ff.z <= csr_data;
            CSR_POINTS_IN_USE: points_ff  <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en) begin
         s0_h_ff   <= req_data.height;
         s0_vel_ff <= {req_data.vel_z, req_data.vel_y, req_data.vel_x};
      end
   end

   htdf_lookup u_lookup (
      .clock         (clock),
      .en            (en),
      .wr            (wr),
      .wr_index      (req_data.point_index),
      .wr_height     (req_data.height),
      .wr_coeff      (req_data.coefficient),
      .points_in_use (points_ff),
      .height        (s0_h_ff),
      .look          (look)
   );

   // squares of the velocity magnitudes
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = WIDE_W'(mag32(s0_vel_ff[a])) * WIDE_W'(mag32(s0_vel_ff[a]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_h_ff   <= s0_h_ff;
         s1_vel_ff <= s0_vel_ff;
         s1_sq_ff  <= sq_in;
      end
   end

   // differences of the bracketing pair, sum of squares
   always_comb begin
      dc_in          = {look.cu[DATA_W-1], look.cu} - {look.cl[DATA_W-1], look.cl};
      dc_mag_in      = dc_in[DATA_W] ? DATA_W'(~dc_in + (DATA_W+1)'(1)) : dc_in[DATA_W-1:0];
      dh_in          = s1_h_ff - look.yl;
      den_in         = look.yu - look.yl;
      sumsq_in       = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      band_in.hit    = look.hit;
      band_in.first  = look.first;
      band_in.dc_neg = dc_in[DATA_W];
      band_in.cl     = look.cl;
      band_in.cu     = look.cu;
      band_in.vel    = s1_vel_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_band_ff   <= band_in;
         s2_dc_mag_ff <= dc_mag_in;
         s2_dh_ff     <= dh_in;
         s2_den_ff    <= den_in;
         s2_sumsq_ff  <= sumsq_in;
         s3_band_ff   <= s2_band_ff;
         s3_num_ff    <= WIDE_W'(s2_dc_mag_ff) * WIDE_W'(s2_dh_ff);
         s3_den_ff    <= s2_den_ff;
         s3_sumsq_ff  <= s2_sumsq_ff;
      end
   end

   htdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_band   (s3_band_ff),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_band  (dv_band)
   );

   htdf_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .in_val   (s3_sumsq_ff),
      .out_root (root)
   );

   // interpolated coefficient
   always_comb begin
      interp_in = dv_band.dc_neg ? ({dv_band.cl[DATA_W-1], dv_band.cl} - {1'b0, dv_q})
                                 : ({dv_band.cl[DATA_W-1], dv_band.cl} + {1'b0, dv_q});
      coef_in.hit   = dv_band.hit;
      coef_in.speed = root;
      coef_in.vel   = dv_band.vel;
      if (!dv_band.hit) begin
         coef_in.coeff = '0;
      end else if (dv_band.first) begin
         coef_in.coeff = dv_band.cu;
      end else begin
         coef_in.coeff = interp_in[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coef_ff <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         coef_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff   <= accept && (req_data.command == CMD_COMPUTE);
         s1_valid_ff   <= s0_valid_ff;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         coef_valid_ff <= dv_valid;
      end
   end

   htdf_force u_force (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (coef_valid_ff),
      .in_coef   (coef_ff),
      .gains     (gains_ff),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   `HTDF_ASSERT_NEXT(a_load_gives_no_beat, clock, reset,
      req_valid && !req_stall && (req_data.command == CMD_LOAD), !s0_valid_ff)
   `HTDF_ASSERT(a_above_table_zero, clock, reset,
      (rsp_valid && rsp_data.above_table) |-> (rsp_data.force_x == '0 &&
      rsp_data.force_y == '0 && rsp_data.force_z == '0 &&
      rsp_data.interp_coeff == '0 && !rsp_data.saturated))
   `HTDF_ASSERT_NEXT(a_pipe_frozen_on_stall, clock, reset,
      rsp_valid && rsp_stall, $stable(s0_valid_ff) && $stable(s3_valid_ff) &&
      $stable(coef_valid_ff))

endmodule
